[rtl/core/hard_sphere_collision_time_unit_assert.svh]
`ifndef HARD_SPHERE_COLLISION_TIME_UNIT_ASSERT_SVH
`define HARD_SPHERE_COLLISION_TIME_UNIT_ASSERT_SVH
// Assertion macros for the hard-sphere collision time unit; expect clk and rst in scope.
`define HSCT_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsct: implication check failed");
`define HSCT_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsct: next-cycle check failed");
`endif

[rtl/core/hsct_pkg.sv]
// Shared constants and types of the hard-sphere collision time unit.
package hsct_pkg;
  localparam int TIME_W = 32;
  localparam int SIGMA_W = 31;
  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 31'd655;
  localparam logic [TIME_W-1:0] TIME_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0] TIME_NEG_LIM = 32'h8000_0000;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;
endpackage

[rtl/core/hsct_mul.sv]
// Two-stage signed multiplier built from four half-width partial products.
module hsct_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic        [AL+BL-1:0] pp_ll;
  logic signed [AL+BH:0]   pp_lh;
  logic signed [AH+BL:0]   pp_hl;
  logic signed [AH+BH-1:0] pp_hh;
  logic        [PW-1:0]    sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= a[AL-1:0] * b[BL-1:0];
      pp_lh <= $signed({1'b0, a[AL-1:0]}) * $signed(b[BW-1:BL]);
      pp_hl <= $signed(a[AW-1:AL]) * $signed({1'b0, b[BL-1:0]});
      pp_hh <= $signed(a[AW-1:AL]) * $signed(b[BW-1:BL]);
      p     <= $signed(sum);
    end
  end

  // Low half of a times high half of b weighs 2^BL; high half of a times low half of b, 2^AL.
  assign sum = (PW'(pp_hh) << (AL + BL)) + (PW'(pp_lh) << BL) + (PW'(pp_hl) << AL)
             + PW'(pp_ll);
endmodule

[rtl/core/hsct_front.sv]
// Front end: relative position and velocity, dot products, approach classification.
module hsct_front #(
  parameter int W = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [W-1:0]       a_pos_x,
  input  logic signed [W-1:0]       a_pos_y,
  input  logic signed [W-1:0]       a_pos_z,
  input  logic signed [W-1:0]       b_pos_x,
  input  logic signed [W-1:0]       b_pos_y,
  input  logic signed [W-1:0]       b_pos_z,
  input  logic signed [W-1:0]       a_vel_x,
  input  logic signed [W-1:0]       a_vel_y,
  input  logic signed [W-1:0]       a_vel_z,
  input  logic signed [W-1:0]       b_vel_x,
  input  logic signed [W-1:0]       b_vel_y,
  input  logic signed [W-1:0]       b_vel_z,
  input  hsct_pkg::q_status_t       q_status,
  output logic                      q_push,
  output logic signed [2*W+3:0]     q_b,
  output logic signed [2*W+3:0]     q_v2,
  output logic signed [2*W+3:0]     q_r2,
  output logic                      q_flag
);
  localparam int DW = W + 1;
  localparam int PW = 2 * DW + 2;

  logic                    en;
  logic [3:0]              vld;
  logic signed [W-1:0]     pa [3];
  logic signed [W-1:0]     pb [3];
  logic signed [W-1:0]     va [3];
  logic signed [W-1:0]     vb [3];
  logic signed [DW-1:0]    r [3];
  logic signed [DW-1:0]    v [3];
  logic signed [2*DW-1:0]  prv [3];
  logic signed [2*DW-1:0]  pvv [3];
  logic signed [2*DW-1:0]  prr [3];
  logic signed [PW-1:0]    b_sum;
  logic signed [PW-1:0]    v2_sum;
  logic signed [PW-1:0]    r2_sum;

  assign pa[0] = a_pos_x;
  assign pa[1] = a_pos_y;
  assign pa[2] = a_pos_z;
  assign pb[0] = b_pos_x;
  assign pb[1] = b_pos_y;
  assign pb[2] = b_pos_z;
  assign va[0] = a_vel_x;
  assign va[1] = a_vel_y;
  assign va[2] = a_vel_z;
  assign vb[0] = b_vel_x;
  assign vb[1] = b_vel_y;
  assign vb[2] = b_vel_z;

  // Advance unless the last stage holds a word the queue cannot take.
  assign en       = !vld[3] || !q_status.full;
  assign in_ready = en;
  assign q_push   = vld[3] && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r[i] <= DW'(pa[i]) - DW'(pb[i]);
        v[i] <= DW'(va[i]) - DW'(vb[i]);
      end
      q_b    <= b_sum;
      q_v2   <= v2_sum;
      q_r2   <= r2_sum;
      q_flag <= b_sum[PW-1] && (v2_sum != '0);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    hsct_mul #(.AW(DW), .BW(DW)) u_rv (.clk(clk), .en(en), .a(r[g]), .b(v[g]), .p(prv[g]));
    hsct_mul #(.AW(DW), .BW(DW)) u_vv (.clk(clk), .en(en), .a(v[g]), .b(v[g]), .p(pvv[g]));
    hsct_mul #(.AW(DW), .BW(DW)) u_rr (.clk(clk), .en(en), .a(r[g]), .b(r[g]), .p(prr[g]));
  end

  assign b_sum  = PW'(prv[0]) + PW'(prv[1]) + PW'(prv[2]);
  assign v2_sum = PW'(pvv[0]) + PW'(pvv[1]) + PW'(pvv[2]);
  assign r2_sum = PW'(prr[0]) + PW'(prr[1]) + PW'(prr[2]);
endmodule

[rtl/core/hsct_queue.sv]
// Short register queue between the front end and the back end.
module hsct_queue #(
  parameter int WIDTH = 205,
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                pop,
  output logic [WIDTH-1:0]    rdata,
  output hsct_pkg::q_status_t status
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign rdata        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

[rtl/core/hsct_back.sv]
// Back end: discriminant, pipelined square root, pipelined divide, saturation.
module hsct_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hsct_pkg::q_status_t                 q_status,
  output logic                                q_pop,
  input  logic signed [2*W+3:0]               q_b,
  input  logic signed [2*W+3:0]               q_v2,
  input  logic signed [2*W+3:0]               q_r2,
  input  logic                                q_flag,
  input  logic [hsct_pkg::SIGMA_W-1:0]        sigma,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                collides,
  output logic signed [hsct_pkg::TIME_W-1:0]  collision_time,
  output logic                                time_overflow
);
  localparam int DW   = W + 1;
  localparam int PW   = 2 * DW + 2;
  localparam int NBW  = PW + 1;
  localparam int SW   = hsct_pkg::SIGMA_W + F;
  localparam int RSW  = ((PW > SW) ? PW : SW) + 1;
  localparam int BBW  = 2 * PW;
  localparam int VRW  = PW + RSW;
  localparam int DSW  = ((BBW > VRW) ? BBW : VRW) + 1;
  localparam int DUW  = DSW - 1;
  localparam int SRW  = (DUW + 1) / 2;
  localparam int RADW = 2 * SRW;
  localparam int MW   = (PW > SRW) ? PW : SRW;
  localparam int NW   = MW + 1;
  localparam int MSW  = MW + F;
  localparam int TW   = hsct_pkg::TIME_W;
  localparam int HW   = MSW - TW;
  localparam int CW   = (HW > PW) ? HW : PW;
  localparam int LAT  = 4 + SRW + 3 + TW + 1;

  logic              en;
  logic [LAT-1:0]    vld;
  logic [SW-1:0]     sig_sh;

  logic signed [PW-1:0]  s0_b;
  logic signed [PW-1:0]  s0_v2;
  logic signed [RSW-1:0] s0_rs;
  logic signed [NBW-1:0] s0_nb;
  logic                  s0_hit;
  logic signed [NBW-1:0] s1_nb;
  logic [PW-1:0]         s1_v2;
  logic                  s1_hit;
  logic signed [NBW-1:0] s2_nb;
  logic [PW-1:0]         s2_v2;
  logic                  s2_hit;
  logic signed [BBW-1:0] bb;
  logic signed [VRW-1:0] vr;
  logic signed [DSW-1:0] disc;

  logic [RADW-1:0]       sq_rad  [SRW+1];
  logic [SRW+1:0]        sq_rem  [SRW+1];
  logic [SRW-1:0]        sq_root [SRW+1];
  logic signed [NBW-1:0] sq_nb   [SRW+1];
  logic [PW-1:0]         sq_v2   [SRW+1];
  logic                  sq_hit  [SRW+1];
  logic [SRW+3:0]        sq_sh   [SRW];
  logic [SRW+3:0]        sq_tr   [SRW];
  logic [SRW+3:0]        sq_df   [SRW];
  logic                  sq_ge   [SRW];

  logic signed [NW-1:0]  a_num;
  logic [PW-1:0]         a_v2;
  logic                  a_hit;
  logic [MW-1:0]         b_mag;
  logic                  b_neg;
  logic [PW-1:0]         b_v2;
  logic                  b_hit;
  logic [MSW-1:0]        c_shift;

  logic [PW-1:0]         dv_rem [TW+1];
  logic [TW-1:0]         dv_low [TW+1];
  logic [TW-1:0]         dv_q   [TW+1];
  logic [PW-1:0]         dv_v2  [TW+1];
  logic                  dv_neg [TW+1];
  logic                  dv_big [TW+1];
  logic                  dv_hit [TW+1];
  logic [PW:0]           dv_r   [TW];
  logic [PW:0]           dv_df  [TW];
  logic                  dv_ge  [TW];

  logic [TW-1:0]         e_lim;
  logic                  e_ovf;
  logic [TW-1:0]         e_mag;

  // The whole back pipe moves as one; hold it while the result word waits.
  assign en        = !vld[LAT-1] || out_ready;
  assign q_pop     = en && !q_status.empty;
  assign out_valid = vld[LAT-1];
  assign sig_sh    = {sigma, F'(0)};
  assign disc      = DSW'(bb) - DSW'(vr);
  assign c_shift   = {b_mag, F'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], q_pop};
    end
  end

  hsct_mul #(.AW(PW), .BW(PW))  u_bb (.clk(clk), .en(en), .a(s0_b),  .b(s0_b),  .p(bb));
  hsct_mul #(.AW(PW), .BW(RSW)) u_vr (.clk(clk), .en(en), .a(s0_v2), .b(s0_rs), .p(vr));

  // One root bit per stage: compare 4*root+1 against the shifted remainder.
  always_comb begin
    for (int i = 0; i < SRW; i++) begin
      sq_sh[i] = {sq_rem[i], sq_rad[i][RADW-1 -: 2]};
      sq_tr[i] = {2'b00, sq_root[i], 2'b01};
      sq_df[i] = sq_sh[i] - sq_tr[i];
      sq_ge[i] = (sq_sh[i] >= sq_tr[i]);
    end
  end

  // One quotient bit per stage, restoring.
  always_comb begin
    for (int j = 0; j < TW; j++) begin
      dv_r[j]  = {dv_rem[j], dv_low[j][TW-1]};
      dv_df[j] = dv_r[j] - {1'b0, dv_v2[j]};
      dv_ge[j] = (dv_r[j] >= {1'b0, dv_v2[j]});
    end
  end

  assign e_lim = dv_neg[TW] ? hsct_pkg::TIME_NEG_LIM : hsct_pkg::TIME_POS_LIM;
  assign e_ovf = dv_big[TW] || (dv_q[TW] > e_lim);
  assign e_mag = e_ovf ? e_lim : dv_q[TW];

  always_ff @(posedge clk) begin
    if (en) begin
      s0_b   <= q_b;
      s0_v2  <= q_v2;
      s0_rs  <= RSW'(q_r2) - RSW'(sig_sh);
      s0_nb  <= -NBW'(q_b);
      s0_hit <= q_flag;

      s1_nb  <= s0_nb;
      s1_v2  <= s0_v2;
      s1_hit <= s0_hit;
      s2_nb  <= s1_nb;
      s2_v2  <= s1_v2;
      s2_hit <= s1_hit;

      sq_rad[0]  <= RADW'(disc[DUW-1:0]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_nb[0]   <= s2_nb;
      sq_v2[0]   <= s2_v2;
      sq_hit[0]  <= s2_hit && !disc[DSW-1];

      for (int i = 0; i < SRW; i++) begin
        sq_rad[i+1]  <= sq_rad[i] << 2;
        sq_rem[i+1]  <= sq_ge[i] ? sq_df[i][SRW+1:0] : sq_sh[i][SRW+1:0];
        sq_root[i+1] <= {sq_root[i][SRW-2:0], sq_ge[i]};
        sq_nb[i+1]   <= sq_nb[i];
        sq_v2[i+1]   <= sq_v2[i];
        sq_hit[i+1]  <= sq_hit[i];
      end

      a_num <= NW'(sq_nb[SRW]) - NW'(sq_root[SRW]);
      a_v2  <= sq_v2[SRW];
      a_hit <= sq_hit[SRW];

      b_neg <= a_num[NW-1];
      b_mag <= MW'(a_num[NW-1] ? -a_num : a_num);
      b_v2  <= a_v2;
      b_hit <= a_hit;

      // Quotient needs more than TW bits when the high part reaches the divisor.
      dv_rem[0] <= PW'(c_shift[MSW-1:TW]);
      dv_low[0] <= c_shift[TW-1:0];
      dv_q[0]   <= '0;
      dv_v2[0]  <= b_v2;
      dv_neg[0] <= b_neg;
      dv_big[0] <= (CW'(c_shift[MSW-1:TW]) >= CW'(b_v2));
      dv_hit[0] <= b_hit;

      for (int j = 0; j < TW; j++) begin
        dv_rem[j+1] <= dv_ge[j] ? dv_df[j][PW-1:0] : dv_r[j][PW-1:0];
        dv_low[j+1] <= dv_low[j] << 1;
        dv_q[j+1]   <= {dv_q[j][TW-2:0], dv_ge[j]};
        dv_v2[j+1]  <= dv_v2[j];
        dv_neg[j+1] <= dv_neg[j];
        dv_big[j+1] <= dv_big[j];
        dv_hit[j+1] <= dv_hit[j];
      end

      collides       <= dv_hit[TW];
      collision_time <= !dv_hit[TW] ? '0 : $signed(dv_neg[TW] ? (TW'(0) - e_mag) : e_mag);
      time_overflow  <= dv_hit[TW] && e_ovf;
    end
  end
endmodule

[rtl/core/hard_sphere_collision_time_unit.sv]
// Hard-sphere pair collision time unit: takes one particle pair per cycle and returns
// whether the pair collides and the signed Q16.16 time to contact, saturated with an
// overflow flag. The pipeline accepts a new word every cycle while the result side
// keeps up. The back end runs the discriminant through a digit-serial square root
// of SR bits, SR being the width of the square root of the discriminant (69 at the
// default 32-bit coordinates), and then through a 32-step divider. A queue of
// QUEUE_DEPTH words lets the front keep taking pairs while the result port stalls.
`include "hard_sphere_collision_time_unit_assert.svh"
module hard_sphere_collision_time_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsct_pkg::SIGMA_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       a_pos_x,
  input  logic signed [COORD_WIDTH-1:0]       a_pos_y,
  input  logic signed [COORD_WIDTH-1:0]       a_pos_z,
  input  logic signed [COORD_WIDTH-1:0]       b_pos_x,
  input  logic signed [COORD_WIDTH-1:0]       b_pos_y,
  input  logic signed [COORD_WIDTH-1:0]       b_pos_z,
  input  logic signed [COORD_WIDTH-1:0]       a_vel_x,
  input  logic signed [COORD_WIDTH-1:0]       a_vel_y,
  input  logic signed [COORD_WIDTH-1:0]       a_vel_z,
  input  logic signed [COORD_WIDTH-1:0]       b_vel_x,
  input  logic signed [COORD_WIDTH-1:0]       b_vel_y,
  input  logic signed [COORD_WIDTH-1:0]       b_vel_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                collides,
  output logic signed [hsct_pkg::TIME_W-1:0]  collision_time,
  output logic                                time_overflow
);
  localparam int PW = 2 * (COORD_WIDTH + 1) + 2;
  localparam int QW = 3 * PW + 1;

  logic [hsct_pkg::SIGMA_W-1:0] sigma;
  hsct_pkg::q_status_t          q_stat;
  logic                         q_push;
  logic                         q_pop;
  logic signed [PW-1:0]         f_b;
  logic signed [PW-1:0]         f_v2;
  logic signed [PW-1:0]         f_r2;
  logic                         f_flag;
  logic [QW-1:0]                q_wdata;
  logic [QW-1:0]                q_rdata;
  logic signed [PW-1:0]         r_b;
  logic signed [PW-1:0]         r_v2;
  logic signed [PW-1:0]         r_r2;
  logic                         t_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma <= hsct_pkg::SIGMA_RESET;
    end else if (cfg_valid) begin
      sigma <= cfg_data;
    end
  end

  hsct_front #(.W(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .a_pos_x  (a_pos_x),
    .a_pos_y  (a_pos_y),
    .a_pos_z  (a_pos_z),
    .b_pos_x  (b_pos_x),
    .b_pos_y  (b_pos_y),
    .b_pos_z  (b_pos_z),
    .a_vel_x  (a_vel_x),
    .a_vel_y  (a_vel_y),
    .a_vel_z  (a_vel_z),
    .b_vel_x  (b_vel_x),
    .b_vel_y  (b_vel_y),
    .b_vel_z  (b_vel_z),
    .q_status (q_stat),
    .q_push   (q_push),
    .q_b      (f_b),
    .q_v2     (f_v2),
    .q_r2     (f_r2),
    .q_flag   (f_flag)
  );

  assign q_wdata = {f_b, f_v2, f_r2, f_flag};

  hsct_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_stat)
  );

  assign r_b  = q_rdata[QW-1 -: PW];
  assign r_v2 = q_rdata[QW-PW-1 -: PW];
  assign r_r2 = q_rdata[PW:1];

  hsct_back #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_stat),
    .q_pop          (q_pop),
    .q_b            (r_b),
    .q_v2           (r_v2),
    .q_r2           (r_r2),
    .q_flag         (q_rdata[0]),
    .sigma          (sigma),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .collides       (collides),
    .collision_time (collision_time),
    .time_overflow  (time_overflow)
  );

  assign t_sat = (collision_time == hsct_pkg::TIME_POS_LIM) ||
                 (collision_time == hsct_pkg::TIME_NEG_LIM);

  `HSCT_ASSERT_IMP(a_miss_zero, out_valid && !collides, collision_time == '0 && !time_overflow)
  `HSCT_ASSERT_IMP(a_ovf_hit, out_valid && time_overflow, collides)
  `HSCT_ASSERT_IMP(a_ovf_sat, out_valid && time_overflow, t_sat)
  `HSCT_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full)
  `HSCT_ASSERT_NXT(a_cfg_write, cfg_valid && cfg_ready, sigma == $past(cfg_data))
endmodule
